// ===== sv/kese_pkg.sv =====
// Key escape sequence encoder: shared package.
// Holds the byte-sequence descriptor type, byte constants and key class lookups.
// No dependencies.
`default_nettype none

package kese_pkg;

    // Longest sequence one key can produce, and the index width over it
    localparam int SEQ_MAX   = 8;
    localparam int SEQ_IDX_W = $clog2(SEQ_MAX);

    // Default depth of the queue between front and back
    localparam int KESE_QUEUE_DEPTH = 2;

    // Byte constants
    localparam logic [7:0] BYTE_ESC   = 8'h1B;
    localparam logic [7:0] BYTE_CSI   = 8'h5B;  // '['
    localparam logic [7:0] BYTE_SS3   = 8'h4F;  // 'O'
    localparam logic [7:0] BYTE_SEMI  = 8'h3B;  // ';'
    localparam logic [7:0] BYTE_TILDE = 8'h7E;  // '~'
    localparam logic [7:0] BYTE_U     = 8'h75;  // 'u'
    localparam logic [7:0] BYTE_P     = 8'h50;  // 'P'
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CTRL_LIFT  = 8'h60;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    // Key class codes
    localparam logic [4:0] KC_CHAR  = 5'd0;
    localparam logic [4:0] KC_UP    = 5'd1;
    localparam logic [4:0] KC_DOWN  = 5'd2;
    localparam logic [4:0] KC_RIGHT = 5'd3;
    localparam logic [4:0] KC_LEFT  = 5'd4;
    localparam logic [4:0] KC_HOME  = 5'd5;
    localparam logic [4:0] KC_END   = 5'd6;
    localparam logic [4:0] KC_INS   = 5'd7;
    localparam logic [4:0] KC_DEL   = 5'd8;
    localparam logic [4:0] KC_PGUP  = 5'd9;
    localparam logic [4:0] KC_PGDN  = 5'd10;
    localparam logic [4:0] KC_F1    = 5'd11;
    localparam logic [4:0] KC_F2    = 5'd12;
    localparam logic [4:0] KC_F3    = 5'd13;
    localparam logic [4:0] KC_F4    = 5'd14;
    localparam logic [4:0] KC_F5    = 5'd15;
    localparam logic [4:0] KC_F6    = 5'd16;
    localparam logic [4:0] KC_F7    = 5'd17;
    localparam logic [4:0] KC_F8    = 5'd18;
    localparam logic [4:0] KC_F9    = 5'd19;
    localparam logic [4:0] KC_F10   = 5'd20;
    localparam logic [4:0] KC_F11   = 5'd21;
    localparam logic [4:0] KC_F12   = 5'd22;
    localparam logic [4:0] KC_ENTER = 5'd23;

    // One encoded key: bytes in order from index 0, and length minus one
    typedef struct packed {
        logic [SEQ_MAX-1:0][7:0] bytes;
        logic [SEQ_IDX_W-1:0]    len_m1;
    } kese_seq_t;

    // Final byte of cursor, Home and End keys
    function automatic logic [7:0] cursor_final(input logic [4:0] cls);
        logic [7:0] f;
        case (cls)
            KC_UP:    f = 8'h41;  // 'A'
            KC_DOWN:  f = 8'h42;  // 'B'
            KC_RIGHT: f = 8'h43;  // 'C'
            KC_LEFT:  f = 8'h44;  // 'D'
            KC_HOME:  f = 8'h48;  // 'H'
            KC_END:   f = 8'h46;  // 'F'
            default:  f = 8'h41;
        endcase
        return f;
    endfunction

    // Number ahead of '~' for editing keys and F5-F12
    function automatic logic [7:0] tilde_num(input logic [4:0] cls);
        logic [7:0] n;
        case (cls)
            KC_INS:  n = 8'd2;
            KC_DEL:  n = 8'd3;
            KC_PGUP: n = 8'd5;
            KC_PGDN: n = 8'd6;
            KC_F5:   n = 8'd15;
            KC_F6:   n = 8'd17;
            KC_F7:   n = 8'd18;
            KC_F8:   n = 8'd19;
            KC_F9:   n = 8'd20;
            KC_F10:  n = 8'd21;
            KC_F11:  n = 8'd23;
            KC_F12:  n = 8'd24;
            default: n = 8'd2;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== sv/key_escape_sequence_encoder.sv =====
// Key escape sequence encoder: top level.
// Ties front end, descriptor queue and back end together; depends on kese_pkg.
//
// Usage:
//  - Input channel (in_valid / in_stall) takes one key event per transaction:
//    key_class, key_char and the Shift, Alt and Ctrl flags.
//  - Output channel (out_valid / out_stall) gives one byte per transaction,
//    with last_byte set on the final byte of each key's sequence. A key gives
//    one to eight bytes; a character key with a zero character gives none.
//  - cfg_wr_en / cfg_wr_data write the CSI-u mode bit; write only when idle.
//  - The first byte of a key is registered in the queue and then in the output
//    register before it is presented. The back end emits one byte per cycle
//    while out_stall is low, so a key holds it until its last byte is loaded.
//  - A new event is taken every cycle while the queue (QUEUE_DEPTH entries)
//    has room; in_stall is high only when it is full.
//  - When the receiver stalls, the output byte holds and the queue fills,
//    after which in_stall rises.
//  - Reset clears the mode bit to 0 and empties the queue and output register.
`default_nettype none

module key_escape_sequence_encoder
    import kese_pkg::*;
#(
    parameter int QUEUE_DEPTH = KESE_QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [4:0] key_class,
    input  wire logic [7:0] key_char,
    input  wire logic       shift_held,
    input  wire logic       alt_held,
    input  wire logic       ctrl_held,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            last_byte
);

    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_head_valid;
    kese_seq_t q_push_data;
    kese_seq_t q_head_data;

    // Front end: classify and build sequences
    kese_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .key_class   (key_class),
        .key_char    (key_char),
        .shift_held  (shift_held),
        .alt_held    (alt_held),
        .ctrl_held   (ctrl_held),
        .q_full      (q_full),
        .in_stall    (in_stall),
        .q_push      (q_push),
        .q_data      (q_push_data)
    );

    // Queue between the two sides
    kese_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_data  (q_head_data)
    );

    // Back end: byte serialiser
    kese_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_data  (q_head_data),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .last_byte  (last_byte)
    );

    // Checks
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head_valid)
        else $error("queue read while empty");

    a_pop_gives_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (out_valid && last_byte))
        else $error("sequence retired without its last byte presented");

endmodule

`default_nettype wire

// ===== sv/kese_front.sv =====
// Key escape sequence encoder: front end.
// Accepts key events, classifies them and builds the full byte sequence.
// Depends on kese_pkg.
`default_nettype none

module kese_front
    import kese_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        in_valid,
    input  wire logic [4:0]  key_class,
    input  wire logic [7:0]  key_char,
    input  wire logic        shift_held,
    input  wire logic        alt_held,
    input  wire logic        ctrl_held,
    input  wire logic        q_full,
    output logic             in_stall,
    output logic             q_push,
    output kese_seq_t        q_data
);

    typedef enum logic [1:0] {
        FORM_NONE,
        FORM_ESCSEQ,
        FORM_RAW
    } form_t;

    logic        csi_u_enable_reg;
    logic        csi_u_enable_next;

    form_t       form;
    logic [7:0]  second_b;
    logic        num_en;
    logic [7:0]  num_val;
    logic        param_en;
    logic [7:0]  final_b;
    logic        raw_esc;
    logic [7:0]  raw_b;

    logic        mod_held;
    logic [3:0]  mods;
    logic [7:0]  mod_digit;
    logic [7:0]  cp;

    logic [1:0]  hund;
    logic [7:0]  hund_sub;
    logic [6:0]  rem_val;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [3:0]  units;
    logic [1:0]  ndig;

    logic [3:0]  pos;
    kese_seq_t   seq;

    // Mode register
    assign csi_u_enable_next = cfg_wr_en ? cfg_wr_data : csi_u_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            csi_u_enable_reg <= 1'b0;
        end
        else
        begin
            csi_u_enable_reg <= csi_u_enable_next;
        end
    end

    // Modifier value 1..8 and its digit
    assign mod_held  = shift_held | alt_held | ctrl_held;
    assign mods      = 4'd1 + {3'b000, shift_held} + {2'b00, alt_held, 1'b0}
                     + {1'b0, ctrl_held, 2'b00};
    assign mod_digit = BYTE_ZERO + {4'b0000, mods};

    // Code point in CSI-u mode, control codes lifted under Ctrl
    assign cp = (ctrl_held && (key_char < CTRL_LIMIT)) ? (key_char + CTRL_LIFT) : key_char;

    // Classification
    always_comb
    begin
        form     = FORM_NONE;
        second_b = BYTE_CSI;
        num_en   = 1'b0;
        num_val  = 8'd1;
        param_en = 1'b0;
        final_b  = BYTE_TILDE;
        raw_esc  = 1'b0;
        raw_b    = key_char;
        if (key_class inside {[KC_UP:KC_END]})
        begin
            form     = FORM_ESCSEQ;
            num_en   = mod_held;
            param_en = mod_held;
            final_b  = cursor_final(key_class);
        end
        else if (key_class inside {[KC_INS:KC_PGDN], [KC_F5:KC_F12]})
        begin
            form     = FORM_ESCSEQ;
            num_en   = 1'b1;
            num_val  = tilde_num(key_class);
            param_en = mod_held;
            final_b  = BYTE_TILDE;
        end
        else if (key_class inside {[KC_F1:KC_F4]})
        begin
            // unmodified F1-F4 use SS3 with no parameters
            form     = FORM_ESCSEQ;
            second_b = mod_held ? BYTE_CSI : BYTE_SS3;
            num_en   = mod_held;
            param_en = mod_held;
            final_b  = BYTE_P + {6'b000000, key_class[1:0] - KC_F1[1:0]};
        end
        else if (key_class == KC_ENTER)
        begin
            form    = FORM_RAW;
            raw_esc = alt_held;
            raw_b   = BYTE_CR;
        end
        else if (key_char != 8'h00)
        begin
            // plain characters, also the unused classes
            if (csi_u_enable_reg)
            begin
                form     = FORM_ESCSEQ;
                num_en   = 1'b1;
                num_val  = cp;
                param_en = 1'b1;
                final_b  = BYTE_U;
            end
            else
            begin
                form    = FORM_RAW;
                raw_esc = alt_held;
            end
        end
    end

    // Decimal digits of num_val; tens by reciprocal multiply (exact below 100)
    assign hund      = (num_val >= 8'd200) ? 2'd2 : (num_val >= 8'd100) ? 2'd1 : 2'd0;
    assign hund_sub  = (hund == 2'd2) ? 8'd200 : (hund == 2'd1) ? 8'd100 : 8'd0;
    assign rem_val   = 7'(num_val - hund_sub);
    assign tens_prod = {8'b0, rem_val} * 15'd205;
    assign tens      = tens_prod[14:11];
    assign tens_x10  = {tens, 3'b000} - 7'd0 + {2'b00, tens, 1'b0};
    assign units     = 4'(rem_val - tens_x10);
    assign ndig      = (num_val >= 8'd100) ? 2'd3 : (num_val >= 8'd10) ? 2'd2 : 2'd1;

    // Sequence assembly
    always_comb
    begin
        seq.bytes = '0;
        pos       = 4'd0;
        if (form == FORM_ESCSEQ)
        begin
            seq.bytes[pos[SEQ_IDX_W-1:0]] = BYTE_ESC;
            pos = pos + 4'd1;
            seq.bytes[pos[SEQ_IDX_W-1:0]] = second_b;
            pos = pos + 4'd1;
            if (num_en)
            begin
                if (ndig == 2'd3)
                begin
                    seq.bytes[pos[SEQ_IDX_W-1:0]] = BYTE_ZERO + {6'b000000, hund};
                    pos = pos + 4'd1;
                end
                if (ndig != 2'd1)
                begin
                    seq.bytes[pos[SEQ_IDX_W-1:0]] = BYTE_ZERO + {4'b0000, tens};
                    pos = pos + 4'd1;
                end
                seq.bytes[pos[SEQ_IDX_W-1:0]] = BYTE_ZERO + {4'b0000, units};
                pos = pos + 4'd1;
            end
            if (param_en)
            begin
                seq.bytes[pos[SEQ_IDX_W-1:0]] = BYTE_SEMI;
                pos = pos + 4'd1;
                seq.bytes[pos[SEQ_IDX_W-1:0]] = mod_digit;
                pos = pos + 4'd1;
            end
            seq.bytes[pos[SEQ_IDX_W-1:0]] = final_b;
            pos = pos + 4'd1;
        end
        else if (form == FORM_RAW)
        begin
            if (raw_esc)
            begin
                seq.bytes[pos[SEQ_IDX_W-1:0]] = BYTE_ESC;
                pos = pos + 4'd1;
            end
            seq.bytes[pos[SEQ_IDX_W-1:0]] = raw_b;
            pos = pos + 4'd1;
        end
        seq.len_m1 = SEQ_IDX_W'(pos - 4'd1);
    end

    // Events that produce no bytes are accepted and dropped
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full && (form != FORM_NONE);
    assign q_data   = seq;

endmodule

`default_nettype wire

// ===== sv/kese_queue.sv =====
// Key escape sequence encoder: descriptor queue between front and back.
// Small register FIFO of encoded key sequences.
// Depends on kese_pkg.
`default_nettype none

module kese_queue
    import kese_pkg::*;
#(
    parameter int DEPTH = KESE_QUEUE_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire kese_seq_t push_data,
    input  wire logic      pop,
    output logic           full,
    output logic           head_valid,
    output kese_seq_t      head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kese_seq_t          store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = store_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== sv/kese_back.sv =====
// Key escape sequence encoder: back end.
// Walks the head sequence one byte per cycle into the output register while not stalled.
// Depends on kese_pkg.
`default_nettype none

module kese_back
    import kese_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        head_valid,
    input  wire kese_seq_t   head_data,
    output logic             q_pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             last_byte
);

    logic [SEQ_IDX_W-1:0] idx_reg;
    logic [SEQ_IDX_W-1:0] idx_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           out_byte_reg;
    logic                 last_byte_reg;
    logic                 load;
    logic                 at_last;

    // Output register takes a new byte when empty or being drained
    assign load    = head_valid && (!out_valid_reg || !out_stall);
    assign at_last = (idx_reg == head_data.len_m1);
    assign q_pop   = load && at_last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = at_last ? '0 : idx_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg  <= head_data.bytes[idx_reg];
            last_byte_reg <= at_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = last_byte_reg;

endmodule

`default_nettype wire

// ===== bench/key_escape_sequence_encoder_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for key_escape_sequence_encoder: directed key table, then random keys.
// Expected bytes: typed literals or an in-bench encoder model; needs kese_pkg and the DUT.

module key_escape_sequence_encoder_tb;

    import kese_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int SETTLE_CYCLES  = 16;
    localparam int LONG_HOLD      = 80;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int PHASE_KEYS     = 45;
    localparam int PRINT_LIMIT    = 30;
    localparam int USE_PREDICTOR  = -1;

    // One key event as it crosses the input channel
    typedef struct packed {
        logic [4:0] cls;
        logic [7:0] ch;
        logic       sh;
        logic       alt;
        logic       ctl;
    } key_event_t;

    // One byte of an encoded sequence
    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } seq_byte_t;

    // Directed row: lit_len of USE_PREDICTOR means the encoder model supplies the bytes
    typedef struct {
        logic       mode;
        key_event_t ev;
        int         lit_len;
        logic [63:0] lit;
    } key_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    logic       in_valid;
    logic       in_stall;
    logic [4:0] key_class;
    logic [7:0] key_char;
    logic       shift_held;
    logic       alt_held;
    logic       ctrl_held;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       last_byte;

    seq_byte_t  expected_bytes[$];
    logic [7:0] enc_buf[$];
    key_row_t   key_table[$];
    logic       mode_shadow;
    int         mismatch_count;
    bit         steady_run;
    bit         hold_request;

    key_escape_sequence_encoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .key_class   (key_class),
        .key_char    (key_char),
        .shift_held  (shift_held),
        .alt_held    (alt_held),
        .ctrl_held   (ctrl_held),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_byte   (last_byte)
    );

    always #CLK_HALF clk = ~clk;

    // Run limit, far beyond the slowest correct run
    initial
    begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Encoder model
    // ------------------------------------------------------------------

    function automatic logic [7:0] csi_final_letter(input logic [4:0] cls);
        case (cls)
            KC_UP:    return "A";
            KC_DOWN:  return "B";
            KC_RIGHT: return "C";
            KC_LEFT:  return "D";
            KC_HOME:  return "H";
            default:  return "F";
        endcase
    endfunction

    function automatic logic [7:0] tilde_code(input logic [4:0] cls);
        case (cls)
            KC_INS:  return 8'd2;
            KC_DEL:  return 8'd3;
            KC_PGUP: return 8'd5;
            KC_PGDN: return 8'd6;
            KC_F5:   return 8'd15;
            KC_F6:   return 8'd17;
            KC_F7:   return 8'd18;
            KC_F8:   return 8'd19;
            KC_F9:   return 8'd20;
            KC_F10:  return 8'd21;
            KC_F11:  return 8'd23;
            default: return 8'd24;
        endcase
    endfunction

    // Decimal digits without leading zeros, at most three
    function automatic void put_decimal(input logic [7:0] v);
        if (v >= 8'd100)
            enc_buf.push_back(BYTE_ZERO + v / 8'd100);
        if (v >= 8'd10)
            enc_buf.push_back(BYTE_ZERO + (v / 8'd10) % 8'd10);
        enc_buf.push_back(BYTE_ZERO + v % 8'd10);
    endfunction

    function automatic void put_csi(input logic [7:0] lead, input logic [7:0] fin,
                                    input logic [7:0] mods, input logic tilde);
        enc_buf.push_back(BYTE_ESC);
        enc_buf.push_back(BYTE_CSI);
        if (tilde || mods != 8'd1)
            put_decimal(lead);
        if (mods != 8'd1)
        begin
            enc_buf.push_back(BYTE_SEMI);
            put_decimal(mods);
        end
        enc_buf.push_back(fin);
    endfunction

    // Work out the byte sequence of one accepted key and queue it
    function automatic void predict_bytes(input key_event_t ev);
        logic [7:0] mods;
        logic [7:0] code;
        seq_byte_t  sb;
        enc_buf.delete();
        mods = 8'd1 + {7'd0, ev.sh} + {6'd0, ev.alt, 1'b0} + {5'd0, ev.ctl, 2'b0};
        if (ev.cls >= KC_UP && ev.cls <= KC_END)
            put_csi(8'd1, csi_final_letter(ev.cls), mods, 1'b0);
        else if (ev.cls >= KC_INS && ev.cls <= KC_PGDN)
            put_csi(tilde_code(ev.cls), BYTE_TILDE, mods, 1'b1);
        else if (ev.cls >= KC_F1 && ev.cls <= KC_F4)
        begin
            code = BYTE_P + {3'd0, ev.cls - KC_F1};
            if (mods == 8'd1)
            begin
                enc_buf.push_back(BYTE_ESC);
                enc_buf.push_back(BYTE_SS3);
                enc_buf.push_back(code);
            end
            else
                put_csi(8'd1, code, mods, 1'b0);
        end
        else if (ev.cls >= KC_F5 && ev.cls <= KC_F12)
            put_csi(tilde_code(ev.cls), BYTE_TILDE, mods, 1'b1);
        else if (ev.cls == KC_ENTER)
        begin
            if (ev.alt)
                enc_buf.push_back(BYTE_ESC);
            enc_buf.push_back(BYTE_CR);
        end
        else if (ev.ch != 8'd0)
        begin
            // character class, unused classes included
            if (mode_shadow)
            begin
                code = ev.ch;
                if (ev.ctl && code < CTRL_LIMIT)
                    code = code + CTRL_LIFT;
                enc_buf.push_back(BYTE_ESC);
                enc_buf.push_back(BYTE_CSI);
                put_decimal(code);
                enc_buf.push_back(BYTE_SEMI);
                put_decimal(mods);
                enc_buf.push_back(BYTE_U);
            end
            else
            begin
                if (ev.alt)
                    enc_buf.push_back(BYTE_ESC);
                enc_buf.push_back(ev.ch);
            end
        end
        for (int i = 0; i < enc_buf.size(); i++)
        begin
            sb.data    = enc_buf[i];
            sb.is_last = (i == enc_buf.size() - 1);
            expected_bytes.push_back(sb);
        end
    endfunction

    // Literal typed into the table: right-aligned string, first byte highest
    function automatic void push_literal(input int len, input logic [63:0] lit);
        seq_byte_t sb;
        for (int i = 0; i < len; i++)
        begin
            sb.data    = lit[8 * (len - 1 - i) +: 8];
            sb.is_last = (i == len - 1);
            expected_bytes.push_back(sb);
        end
    endfunction

    // ------------------------------------------------------------------
    // Output side: stall pattern and checking
    // ------------------------------------------------------------------

    initial
    begin
        int run_len;
        logic stall_val;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                // long hold-off so the queue fills and the input stalls
                out_stall <= 1'b1;
                for (int k = 1; k < LONG_HOLD; k++)
                    @(negedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                run_len = $urandom_range(0, 99);
                if (steady_run || run_len < 80)
                begin
                    stall_val = 1'b0;
                    run_len   = $urandom_range(1, 4);
                end
                else if (run_len < 97)
                begin
                    stall_val = 1'b1;
                    run_len   = $urandom_range(1, 3);
                end
                else
                begin
                    stall_val = 1'b1;
                    run_len   = $urandom_range(8, 30);
                end
                out_stall <= stall_val;
                repeat (run_len - 1) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : byte_check
        seq_byte_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_bytes.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h last %b", out_byte, last_byte));
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.data)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              out_byte, want.data));
                if (last_byte !== want.is_last)
                    report_mismatch($sformatf("last_byte %b, expected %b on byte %02h",
                                              last_byte, want.is_last, want.data));
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one key and return at the edge where the transaction is taken
    task automatic send_key(input key_event_t ev);
        @(negedge clk);
        in_valid   <= 1'b1;
        key_class  <= ev.cls;
        key_char   <= ev.ch;
        shift_held <= ev.sh;
        alt_held   <= ev.alt;
        ctrl_held  <= ev.ctl;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
    endtask

    // Gap after a transaction; zero keeps valid high for the next key
    task automatic idle_sender();
        int gap;
        gap = $urandom_range(0, 99);
        if (steady_run || gap < 75)
            gap = 0;
        else if (gap < 95)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 30);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stop offering and wait until every queued byte has come out
    task automatic await_all_bytes();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        await_all_bytes();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        mode_shadow = mode;
    endtask

    function automatic key_event_t random_key();
        key_event_t ev;
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            ev.cls = KC_CHAR;
        else if (r < 40)
            ev.cls = 5'($urandom_range(24, 31));
        else if (r < 90)
            ev.cls = 5'($urandom_range(1, 22));
        else
            ev.cls = KC_ENTER;
        r = $urandom_range(0, 99);
        if (r < 10)
            ev.ch = 8'd0;
        else if (r < 25)
            ev.ch = 8'($urandom_range(1, 31));
        else if (r < 35)
            ev.ch = 8'hFF;
        else
            ev.ch = 8'($urandom_range(0, 255));
        ev.sh  = 1'($urandom_range(0, 1));
        ev.alt = 1'($urandom_range(0, 1));
        ev.ctl = 1'($urandom_range(0, 1));
        return ev;
    endfunction

    task automatic add_row(input logic mode, input logic [4:0] cls, input logic [7:0] ch,
                           input logic sh, input logic alt, input logic ctl,
                           input int lit_len, input logic [63:0] lit);
        key_row_t row;
        row.mode    = mode;
        row.ev.cls  = cls;
        row.ev.ch   = ch;
        row.ev.sh   = sh;
        row.ev.alt  = alt;
        row.ev.ctl  = ctl;
        row.lit_len = lit_len;
        row.lit     = lit;
        key_table.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        int wait_cycles;
        logic phase_mode [5];
        key_event_t rand_ev;
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 1'b0;
        in_valid       = 1'b0;
        key_class      = KC_CHAR;
        key_char       = 8'd0;
        shift_held     = 1'b0;
        alt_held       = 1'b0;
        ctrl_held      = 1'b0;
        mode_shadow    = 1'b0;
        mismatch_count = 0;
        steady_run     = 1'b0;
        hold_request   = 1'b0;
        phase_mode     = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

        // mode, class, char, shift, alt, ctrl, typed length, typed bytes
        add_row(1'b0, KC_UP,    8'h00, 1'b0, 1'b0, 1'b0, 3, "\033[A");
        add_row(1'b0, KC_DOWN,  8'h00, 1'b1, 1'b0, 1'b0, 6, "\033[1;2B");
        add_row(1'b0, KC_RIGHT, 8'h41, 1'b0, 1'b1, 1'b0, USE_PREDICTOR, 64'd0);
        add_row(1'b0, KC_LEFT,  8'h00, 1'b1, 1'b1, 1'b1, 6, "\033[1;8D");
        add_row(1'b0, KC_HOME,  8'h00, 1'b0, 1'b0, 1'b0, 3, "\033[H");
        add_row(1'b0, KC_END,   8'hFF, 1'b0, 1'b0, 1'b1, USE_PREDICTOR, 64'd0);
        add_row(1'b0, KC_INS,   8'h00, 1'b0, 1'b0, 1'b0, 4, "\033[2~");
        add_row(1'b0, KC_DEL,   8'h00, 1'b0, 1'b1, 1'b0, USE_PREDICTOR, 64'd0);
        add_row(1'b0, KC_PGUP,  8'h00, 1'b0, 1'b0, 1'b0, USE_PREDICTOR, 64'd0);
        add_row(1'b0, KC_PGDN,  8'h00, 1'b1, 1'b1, 1'b1, 6, "\033[6;8~");
        add_row(1'b0, KC_F1,    8'h00, 1'b0, 1'b0, 1'b0, 3, "\033OP");
        add_row(1'b0, KC_F2,    8'h00, 1'b0, 1'b0, 1'b0, USE_PREDICTOR, 64'd0);
        add_row(1'b0, KC_F4,    8'h00, 1'b1, 1'b0, 1'b0, 6, "\033[1;2S");
        add_row(1'b0, KC_F5,    8'h00, 1'b0, 1'b0, 1'b0, 5, "\033[15~");
        add_row(1'b0, KC_F12,   8'h00, 1'b1, 1'b1, 1'b1, 7, "\033[24;8~");
        // enter ignores the character byte
        add_row(1'b0, KC_ENTER, 8'hFF, 1'b0, 1'b1, 1'b0, 2, "\033\015");
        // zero character: nothing comes out
        add_row(1'b0, KC_CHAR,  8'h00, 1'b1, 1'b1, 1'b1, 0, 64'd0);
        add_row(1'b0, KC_CHAR,  8'hFF, 1'b0, 1'b1, 1'b0, USE_PREDICTOR, 64'd0);
        add_row(1'b0, KC_CHAR,  8'h61, 1'b0, 1'b0, 1'b0, 1, "a");
        // unused class behaves as a character
        add_row(1'b0, 5'd31,    8'h61, 1'b1, 1'b1, 1'b1, USE_PREDICTOR, 64'd0);
        add_row(1'b1, KC_CHAR,  8'h61, 1'b0, 1'b0, 1'b0, 7, "\033[97;1u");
        // control lift: 0x01 under Ctrl reports as 97
        add_row(1'b1, KC_CHAR,  8'h01, 1'b0, 1'b0, 1'b1, 7, "\033[97;5u");
        add_row(1'b1, KC_CHAR,  8'h1F, 1'b1, 1'b1, 1'b0, USE_PREDICTOR, 64'd0);
        add_row(1'b1, KC_CHAR,  8'hFF, 1'b1, 1'b1, 1'b1, 8, "\033[255;8u");
        add_row(1'b1, KC_CHAR,  8'h00, 1'b0, 1'b0, 1'b1, 0, 64'd0);
        add_row(1'b1, KC_ENTER, 8'h61, 1'b1, 1'b0, 1'b1, USE_PREDICTOR, 64'd0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table, checked against typed bytes where given
        foreach (key_table[i])
        begin
            if (key_table[i].mode != mode_shadow)
                write_mode(key_table[i].mode);
            send_key(key_table[i].ev);
            if (key_table[i].lit_len == USE_PREDICTOR)
                predict_bytes(key_table[i].ev);
            else
                push_literal(key_table[i].lit_len, key_table[i].lit);
            idle_sender();
        end

        // Random phases, one mode setting each
        for (int p = 0; p < 5; p++)
        begin
            write_mode(phase_mode[p]);
            for (int i = 0; i < PHASE_KEYS; i++)
            begin
                steady_run = (i >= 30 && i < 40);
                if (p == 1 && i == 10)
                    hold_request = 1'b1;
                if (p == 2 && i == 25)
                    await_all_bytes();
                rand_ev = random_key();
                send_key(rand_ev);
                predict_bytes(rand_ev);
                idle_sender();
            end
            steady_run = 1'b0;
        end

        // Drain, bounded
        @(negedge clk);
        in_valid <= 1'b0;
        wait_cycles = 0;
        while (expected_bytes.size() != 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (expected_bytes.size() != 0)
            report_mismatch($sformatf("%0d bytes never arrived", expected_bytes.size()));
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
